@@ hw/rtl/suffix_array_prefix_doubling_assert.svh @@
// Assertion macros used by the checker file.
`ifndef SUFFIX_ARRAY_PREFIX_DOUBLING_ASSERT_SVH
`define SUFFIX_ARRAY_PREFIX_DOUBLING_ASSERT_SVH
// Same-cycle implication, sampled on clk_i, off during reset.
`define SAPD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sapd assertion failed");
// Next-cycle implication, sampled on clk_i, off during reset.
`define SAPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sapd assertion failed");
`endif

@@ hw/rtl/sapd_pkg.sv @@
// ----------------------------------------------------------------------------
// sapd_pkg
// Types and constants of the prefix-doubling suffix array builder.
// ----------------------------------------------------------------------------
package sapd_pkg;

  localparam int SYM_W = 8;
  localparam int POS_W = 6;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             final_res;
    logic             overflow;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SENT,
    ST_RD_I,
    ST_LAT_I,
    ST_RD_J,
    ST_CMP,
    ST_WR,
    ST_EMIT_RD,
    ST_EMIT_SH
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic sent;
    logic rd_i;
    logic lat_i;
    logic rd_j;
    logic cmp;
    logic wr;
    logic next_round;
    logic emit_init;
    logic emit_rd;
    logic emit_show;
    logic done;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic last_i;
    logic last_j;
    logic last_round;
    logic last_emit;
    logic out_busy;
  } sts_t;

endpackage

@@ hw/rtl/sapd_ctrl.sv @@
// ----------------------------------------------------------------------------
// sapd_ctrl
// Sequencer: load, counting-sort rounds, and emission of the suffix array.
// ----------------------------------------------------------------------------
module sapd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_last_i,
  input  sapd_pkg::sts_t sts_i,
  output logic          in_ready_o,
  output sapd_pkg::cmd_t cmd_o
);
  import sapd_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (in_valid_i && in_last_i) state_d = ST_SENT;
      end
      ST_SENT:  state_d = ST_RD_I;
      ST_RD_I:  state_d = ST_LAT_I;
      ST_LAT_I: state_d = ST_RD_J;
      ST_RD_J:  state_d = ST_CMP;
      ST_CMP: begin
        state_d = sts_i.last_j ? ST_WR : ST_RD_J;
      end
      ST_WR: begin
        if (!sts_i.last_i) state_d = ST_RD_I;
        else if (sts_i.last_round) state_d = ST_EMIT_RD;
        else state_d = ST_RD_I;
      end
      ST_EMIT_RD: state_d = ST_EMIT_SH;
      ST_EMIT_SH: begin
        if (!sts_i.out_busy) state_d = sts_i.last_emit ? ST_LOAD : ST_EMIT_RD;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_SENT:  cmd_o.sent = 1'b1;
      ST_RD_I:  cmd_o.rd_i = 1'b1;
      ST_LAT_I: cmd_o.lat_i = 1'b1;
      ST_RD_J:  cmd_o.rd_j = 1'b1;
      ST_CMP:   cmd_o.cmp = 1'b1;
      ST_WR: begin
        cmd_o.wr         = 1'b1;
        cmd_o.next_round = sts_i.last_i && !sts_i.last_round;
        cmd_o.emit_init  = sts_i.last_i && sts_i.last_round;
      end
      ST_EMIT_RD: cmd_o.emit_rd = 1'b1;
      ST_EMIT_SH: begin
        cmd_o.emit_show = !sts_i.out_busy;
        cmd_o.done      = !sts_i.out_busy && sts_i.last_emit;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

@@ hw/rtl/sapd_dp.sv @@
// ----------------------------------------------------------------------------
// sapd_dp
// Rank memories, order memory, counters, comparator and output register.
// ----------------------------------------------------------------------------
module sapd_dp #(
  parameter int MaxLen = 63
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sapd_pkg::cmd_t      cmd_i,
  input  sapd_pkg::in_item_t  in_data_i,
  input  logic                out_ready_i,
  output sapd_pkg::sts_t      sts_o,
  output logic                out_valid_o,
  output sapd_pkg::out_item_t out_data_o
);
  import sapd_pkg::*;

  localparam int Depth = MaxLen + 1;
  localparam int W     = $clog2(Depth);
  localparam int NW    = W + 1;
  localparam int RW    = (W > SYM_W + 1) ? W : SYM_W + 1;
  localparam int MemD  = 2 ** W;

  logic [RW-1:0] rank_mem [0:2*MemD-1];
  logic [W-1:0]  order_mem [0:MemD-1];

  logic [NW-1:0] len_q, sh_q, i_q, j_q, k_q;
  logic          ovf_q, bank_q;
  logic [W-1:0]  acc_q, ord_q;
  logic [RW-1:0] hi_q, lo_q, rda_q, rdb_q;
  logic          ovalid_q;
  out_item_t     out_q;

  logic [NW-1:0] n, base;
  logic [NW:0]   sum;
  logic [W-1:0]  a_idx, b_idx;
  logic          room, lt;

  assign n     = len_q + NW'(1);
  assign room  = len_q < NW'(MaxLen);
  assign base  = cmd_i.rd_i ? i_q : j_q;
  assign a_idx = base[W-1:0];
  assign sum   = {1'b0, base} + {1'b0, sh_q};

  // Wrap the partner index modulo n
  always_comb begin
    if (sum >= {1'b0, n}) b_idx = W'(sum - {1'b0, n});
    else b_idx = W'(sum);
  end

  assign lt = (rda_q < hi_q) || ((rda_q == hi_q) && (rdb_q < lo_q));

  assign sts_o.last_i     = i_q == len_q;
  assign sts_o.last_j     = j_q == len_q;
  assign sts_o.last_round = {sh_q, 1'b0} >= {1'b0, n};
  assign sts_o.last_emit  = k_q == len_q;
  assign sts_o.out_busy   = ovalid_q;

  // Rank memory: write initial keys, sentinel and new ranks; two reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && room) begin
      rank_mem[{bank_q, len_q[W-1:0]}] <= RW'(in_data_i.symbol) + RW'(1);
    end else if (cmd_i.sent) begin
      rank_mem[{bank_q, len_q[W-1:0]}] <= '0;
    end else if (cmd_i.wr && !sts_o.last_round) begin
      rank_mem[{~bank_q, i_q[W-1:0]}] <= RW'(acc_q);
    end
    if (cmd_i.rd_i || cmd_i.rd_j) begin
      rda_q <= rank_mem[{bank_q, a_idx}];
      rdb_q <= rank_mem[{bank_q, b_idx}];
    end
  end

  // Order memory: place each position at its final rank
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && sts_o.last_round) begin
      order_mem[acc_q] <= i_q[W-1:0];
    end
    if (cmd_i.emit_rd) begin
      ord_q <= order_mem[k_q[W-1:0]];
    end
  end

  // Key latch and less-than count
  always_ff @(posedge clk_i) begin
    if (cmd_i.lat_i) begin
      hi_q  <= rda_q;
      lo_q  <= rdb_q;
      acc_q <= '0;
    end else if (cmd_i.cmp && lt) begin
      acc_q <= acc_q + W'(1);
    end
  end

  // Control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      ovf_q  <= 1'b0;
      bank_q <= 1'b0;
      sh_q   <= '0;
      i_q    <= '0;
      j_q    <= '0;
      k_q    <= '0;
    end else begin
      if (cmd_i.load) begin
        if (room) len_q <= len_q + NW'(1);
        else ovf_q <= 1'b1;
      end
      if (cmd_i.sent) begin
        sh_q <= NW'(1);
        i_q  <= '0;
      end
      if (cmd_i.lat_i) j_q <= '0;
      if (cmd_i.cmp) j_q <= j_q + NW'(1);
      if (cmd_i.wr) i_q <= cmd_i.next_round ? '0 : i_q + NW'(1);
      if (cmd_i.next_round) begin
        sh_q   <= {sh_q[NW-2:0], 1'b0};
        bank_q <= ~bank_q;
      end
      if (cmd_i.emit_init) k_q <= '0;
      if (cmd_i.emit_show) k_q <= k_q + NW'(1);
      if (cmd_i.done) begin
        len_q  <= '0;
        ovf_q  <= 1'b0;
        bank_q <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.emit_show) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_show) begin
      out_q.position  <= POS_W'(ord_q);
      out_q.final_res <= sts_o.last_emit;
      out_q.overflow  <= ovf_q;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = out_q;

endmodule

@@ hw/rtl/suffix_array_prefix_doubling.sv @@
// Loading: one byte per cycle, then the sentinel is appended.
// Build: ceil(log2 n) rounds for n = length + 1; in each round the single
// comparator passes each position over all others.
// Emission: each position is read, then shown once the last output is taken.
// Reset (async, active low) returns to loading with an empty string.
// ----------------------------------------------------------------------------
// suffix_array_prefix_doubling
// Builds the suffix array of a byte string plus sentinel by prefix doubling.
// ----------------------------------------------------------------------------
module suffix_array_prefix_doubling #(
  parameter int MaxLen = 63
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sapd_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sapd_pkg::out_item_t out_data_o
);
  import sapd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sapd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.last),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  sapd_dp #(.MaxLen(MaxLen)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

@@ hw/rtl/sapd_checker.sv @@
// ----------------------------------------------------------------------------
// sapd_checker
// Port-level checks of the suffix array builder, bound to the top level.
// ----------------------------------------------------------------------------
`include "suffix_array_prefix_doubling_assert.svh"

module sapd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input sapd_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input sapd_pkg::out_item_t out_data_o
);
  import sapd_pkg::*;

  // Hold a stalled result transaction
  `SAPD_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `SAPD_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(out_data_o))
  // Stop loading once the final byte is taken
  `SAPD_ASSERT_NEXT(a_last_stops, in_valid_i && in_ready_o && in_data_i.last, !in_ready_o)
  // Accept no byte while a non-final position is shown
  `SAPD_ASSERT_SAME(a_no_load_mid, out_valid_o && !out_data_o.final_res, !in_ready_o)

endmodule

bind suffix_array_prefix_doubling sapd_checker u_sapd_checker (.*);
